@@ rtl/extended_axpy_stream_top_macros.svh @@
// Assertion macros for the extended-precision axpy stream.
// Used by extended_axpy_stream_top; expects clk and arst_n in scope.
`ifndef EXTENDED_AXPY_STREAM_TOP_MACROS_SVH
`define EXTENDED_AXPY_STREAM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EAS_CHECK(name, prop) name: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("eas check failed");
`define EAS_CHECK_NEXT(name, ante, cons) name: assert property (@(posedge clk) \
	disable iff (!arst_n) ante |=> cons) else $error("eas next-cycle check failed");
`else
`define EAS_CHECK(name, prop)
`define EAS_CHECK_NEXT(name, ante, cons)
`endif
`endif

@@ rtl/eas_pkg.sv @@
// Types, constants and arithmetic helpers for the extended-precision axpy stream.
// No dependencies.
package eas_pkg;

	localparam logic [14:0] EMAX = 15'h7FFF;
	localparam logic [63:0] TOPBIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] QBIT = 64'h4000_0000_0000_0000;
	localparam logic REG_ALPHA_SE = 1'b0;
	localparam logic REG_ALPHA_SIG = 1'b1;

	typedef logic signed [18:0] exp_t;

	typedef struct packed {
		logic [15:0] se;
		logic [63:0] sig;
	} xval_t;

	typedef enum logic [2:0] {K_ZERO, K_FIN, K_INF, K_NAN, K_BAD} kind_t;

	localparam xval_t DEFAULT_NAN = '{se: 16'hFFFF, sig: 64'hC000_0000_0000_0000};

	function automatic kind_t classify(xval_t v);
		kind_t k;
		if (v.se[14:0] == EMAX) begin
			if (!v.sig[63]) k = K_BAD;
			else k = (v.sig[62:0] == '0) ? K_INF : K_NAN;
		end else if (v.se[14:0] != '0 && !v.sig[63]) begin
			k = K_BAD;
		end else if (v.se[14:0] == '0 && v.sig == '0) begin
			k = K_ZERO;
		end else begin
			k = K_FIN;
		end
		return k;
	endfunction

	function automatic logic [14:0] eff_exp(xval_t v);
		return (v.se[14:0] == '0) ? 15'd1 : v.se[14:0];
	endfunction

	function automatic xval_t pick_nan(xval_t a, kind_t ka, xval_t b, kind_t kb);
		xval_t r;
		logic as_s, bs_s;
		as_s = !a.sig[62];
		bs_s = !b.sig[62];
		if (ka != K_NAN) r = '{se: b.se, sig: b.sig | QBIT};
		else if (kb != K_NAN) r = '{se: a.se, sig: a.sig | QBIT};
		else if (as_s && !bs_s) r = b;
		else if (bs_s && !as_s) r = a;
		else if (b.sig > a.sig) r = '{se: b.se, sig: b.sig | QBIT};
		else r = '{se: a.se, sig: a.sig | QBIT};
		return r;
	endfunction

	function automatic logic [6:0] lzc128(logic [127:0] m);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 128; i++) begin
			if (m[i]) n = 7'(127 - i);
		end
		return n;
	endfunction

	function automatic logic [127:0] shr_jam(logic [127:0] m, logic [18:0] d);
		logic [127:0] r;
		logic [127:0] mask;
		if (d >= 19'd128) begin
			r = {127'b0, |m};
		end else begin
			mask = (128'b1 << d[6:0]) - 128'b1;
			r = m >> d[6:0];
			r[0] = r[0] | (|(m & mask));
		end
		return r;
	endfunction

	// denormalise below the minimum exponent, round to nearest even, overflow to infinity
	function automatic xval_t round_pack(logic sign, exp_t e_in, logic [127:0] m_in);
		logic [127:0] m;
		exp_t e;
		logic up;
		logic [64:0] inc;
		logic [63:0] hi;
		xval_t r;
		m = m_in;
		e = e_in;
		if (e < 19'sd1) begin
			m = shr_jam(m, 19'(19'sd1 - e));
			e = 19'sd1;
		end
		up = (m[63:0] > TOPBIT) || (m[63:0] == TOPBIT && m[64]);
		inc = {1'b0, m[127:64]} + {64'b0, up};
		hi = inc[63:0];
		if (inc[64]) begin
			hi = TOPBIT;
			e = e + 19'sd1;
		end
		if (e >= 19'sd32767) r = '{se: {sign, EMAX}, sig: TOPBIT};
		else r = '{se: {sign, hi[63] ? e[14:0] : 15'd0}, sig: hi};
		return r;
	endfunction

endpackage

@@ rtl/extended_axpy_stream_top.sv @@
// Extended-precision axpy stream: sum = y + alpha * x, eight-stage pipeline.
// Depends on eas_pkg and extended_axpy_stream_top_macros.svh.
//
//  channel | direction | handshake                   | payload
//  s_*     | in        | s_tvalid / s_tready         | x and y elements, s_tlast
//  m_*     | out       | m_tvalid / m_tready         | updated y element, m_tlast
//  p*      | in        | psel, penable, pwrite       | alpha registers at 0x0, 0x8
//
// One word per cycle while the output is not stalled.
// Stages: partial products, product sum, normalise, round, align, add,
// normalise, round. Each stage advances when empty or when its successor
// advances, so bubbles collapse and a stalled output holds the pipe.
// Reset clears all valid bits and the alpha registers.
`include "extended_axpy_stream_top_macros.svh"
module extended_axpy_stream_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// x_sign_exponent, x_significand, y_sign_exponent, y_significand
	input  logic [159:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// sum_sign_exponent, sum_significand
	output logic [79:0]  m_tdata,
	output logic         m_tlast
);
	import eas_pkg::*;

	logic [15:0] alpha_se_q;
	logic [63:0] alpha_sig_q;
	xval_t alpha;
	logic alpha_zero;

	logic v1, v2, v3, v4, v5, v6, v7, v8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	xval_t x_s1, y_s1, y_s2, y_s3, y_s4, y_s5, y_s6, y_s7, y_s8;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7, last_s8;
	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic [127:0] m_s2, m_s3, mb_s5, m_s6, m_s7;
	logic [63:0] ma_s5;
	exp_t e_s2, e_s3, e_s5, e_s6, e_s7;
	logic sgn_s2, sgn_s3, sa_s5, sb_s5, sgn_s6, sgn_s7;
	logic spec_s2, spec_s3, spec_s5, spec_s6, spec_s7;
	xval_t specv_s2, specv_s3, specv_s5, specv_s6, specv_s7;
	xval_t p_s4, out_s8;

	xval_t x_in, y_in;
	assign x_in = '{se: s_tdata[15:0], sig: s_tdata[79:16]};
	assign y_in = '{se: s_tdata[95:80], sig: s_tdata[159:96]};
	assign alpha = '{se: alpha_se_q, sig: alpha_sig_q};
	assign alpha_zero = (alpha_se_q[14:0] == '0) && (alpha_sig_q == '0);

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_ALPHA_SIG) ? alpha_sig_q : {48'b0, alpha_se_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_se_q <= '0;
			alpha_sig_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3])
				REG_ALPHA_SE: alpha_se_q <= pwdata[15:0];
				REG_ALPHA_SIG: alpha_sig_q <= pwdata;
				default: ;
			endcase
		end
	end

	// stage enables
	assign en8 = !v8 || m_tready;
	assign en7 = !v7 || en8;
	assign en6 = !v6 || en7;
	assign en5 = !v5 || en6;
	assign en4 = !v4 || en5;
	assign en3 = !v3 || en4;
	assign en2 = !v2 || en3;
	assign en1 = !v1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
		end else begin
			if (en1) v1 <= s_tvalid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
			if (en5) v5 <= v4;
			if (en6) v6 <= v5;
			if (en7) v7 <= v6;
			if (en8) v8 <= v7;
		end
	end

	// s1: partial products
	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			x_s1 <= x_in;
			y_s1 <= y_in;
			last_s1 <= s_tlast;
			pp00_s1 <= alpha_sig_q[31:0] * x_in.sig[31:0];
			pp01_s1 <= alpha_sig_q[31:0] * x_in.sig[63:32];
			pp10_s1 <= alpha_sig_q[63:32] * x_in.sig[31:0];
			pp11_s1 <= alpha_sig_q[63:32] * x_in.sig[63:32];
		end
	end

	// s2: product sum and product specials
	kind_t ka2, kb2;
	logic psgn2, pspec2;
	xval_t pspecv2;
	assign ka2 = classify(alpha);
	assign kb2 = classify(x_s1);
	assign psgn2 = alpha.se[15] ^ x_s1.se[15];

	always_comb begin
		pspec2 = 1'b1;
		pspecv2 = DEFAULT_NAN;
		if (ka2 == K_BAD || kb2 == K_BAD) pspecv2 = DEFAULT_NAN;
		else if (ka2 == K_NAN || kb2 == K_NAN) pspecv2 = pick_nan(alpha, ka2, x_s1, kb2);
		else if (ka2 == K_INF || kb2 == K_INF) begin
			if (ka2 == K_ZERO || kb2 == K_ZERO) pspecv2 = DEFAULT_NAN;
			else pspecv2 = '{se: {psgn2, EMAX}, sig: TOPBIT};
		end else if (ka2 == K_ZERO || kb2 == K_ZERO) pspecv2 = '{se: {psgn2, 15'd0}, sig: '0};
		else pspec2 = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en2 && v1) begin
			y_s2 <= y_s1;
			last_s2 <= last_s1;
			m_s2 <= {pp11_s1, 64'b0} + {32'b0, pp01_s1, 32'b0} + {32'b0, pp10_s1, 32'b0}
				+ {64'b0, pp00_s1};
			e_s2 <= $signed({4'b0, eff_exp(alpha)}) + $signed({4'b0, eff_exp(x_s1)})
				- 19'sd16382;
			sgn_s2 <= psgn2;
			spec_s2 <= pspec2;
			specv_s2 <= pspecv2;
		end
	end

	// s3: normalise product
	logic [6:0] lz3;
	assign lz3 = lzc128(m_s2);

	always_ff @(posedge clk) begin
		if (en3 && v2) begin
			y_s3 <= y_s2;
			last_s3 <= last_s2;
			m_s3 <= m_s2 << lz3;
			e_s3 <= e_s2 - $signed({12'b0, lz3});
			sgn_s3 <= sgn_s2;
			spec_s3 <= spec_s2;
			specv_s3 <= specv_s2;
		end
	end

	// s4: round product
	always_ff @(posedge clk) begin
		if (en4 && v3) begin
			y_s4 <= y_s3;
			last_s4 <= last_s3;
			p_s4 <= spec_s3 ? specv_s3 : round_pack(sgn_s3, e_s3, m_s3);
		end
	end

	// s5: sum specials, order operands, align
	kind_t ka5, kb5;
	logic aspec5, swap5;
	xval_t aspecv5, big5, sml5;
	logic [14:0] ea5, eb5, eb_big5, eb_sml5;

	assign ka5 = classify(y_s4);
	assign kb5 = classify(p_s4);
	assign ea5 = eff_exp(y_s4);
	assign eb5 = eff_exp(p_s4);
	assign swap5 = (ea5 < eb5) || (ea5 == eb5 && y_s4.sig < p_s4.sig);
	assign big5 = swap5 ? p_s4 : y_s4;
	assign sml5 = swap5 ? y_s4 : p_s4;
	assign eb_big5 = swap5 ? eb5 : ea5;
	assign eb_sml5 = swap5 ? ea5 : eb5;

	always_comb begin
		aspec5 = 1'b1;
		aspecv5 = DEFAULT_NAN;
		if (ka5 == K_BAD || kb5 == K_BAD) aspecv5 = DEFAULT_NAN;
		else if (ka5 == K_NAN || kb5 == K_NAN) aspecv5 = pick_nan(y_s4, ka5, p_s4, kb5);
		else if (ka5 == K_INF && kb5 == K_INF)
			aspecv5 = (y_s4.se[15] ^ p_s4.se[15]) ? DEFAULT_NAN : y_s4;
		else if (ka5 == K_INF) aspecv5 = y_s4;
		else if (kb5 == K_INF) aspecv5 = p_s4;
		else aspec5 = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en5 && v4) begin
			y_s5 <= y_s4;
			last_s5 <= last_s4;
			ma_s5 <= big5.sig;
			mb_s5 <= shr_jam({sml5.sig, 64'b0}, {4'b0, eb_big5 - eb_sml5});
			e_s5 <= $signed({4'b0, eb_big5});
			sa_s5 <= big5.se[15];
			sb_s5 <= sml5.se[15];
			spec_s5 <= aspec5;
			specv_s5 <= aspecv5;
		end
	end

	// s6: add or subtract
	logic [128:0] sum6;
	logic [127:0] r6;
	exp_t e6;
	always_comb begin
		sum6 = {1'b0, ma_s5, 64'b0} + {1'b0, mb_s5};
		e6 = e_s5;
		if (sa_s5 == sb_s5) begin
			r6 = sum6[127:0];
			if (sum6[128]) begin
				r6 = {1'b1, sum6[127:1]} | {127'b0, sum6[0]};
				e6 = e_s5 + 19'sd1;
			end
		end else begin
			r6 = {ma_s5, 64'b0} - mb_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en6 && v5) begin
			y_s6 <= y_s5;
			last_s6 <= last_s5;
			m_s6 <= r6;
			e_s6 <= e6;
			sgn_s6 <= sa_s5;
			spec_s6 <= spec_s5 || (r6 == '0);
			specv_s6 <= spec_s5 ? specv_s5
				: '{se: {(sa_s5 == sb_s5) ? sa_s5 : 1'b0, 15'd0}, sig: '0};
		end
	end

	// s7: normalise sum
	logic [6:0] lz7;
	assign lz7 = lzc128(m_s6);

	always_ff @(posedge clk) begin
		if (en7 && v6) begin
			y_s7 <= y_s6;
			last_s7 <= last_s6;
			m_s7 <= m_s6 << lz7;
			e_s7 <= e_s6 - $signed({12'b0, lz7});
			sgn_s7 <= sgn_s6;
			spec_s7 <= spec_s6;
			specv_s7 <= specv_s6;
		end
	end

	// s8: round sum, output register
	always_ff @(posedge clk) begin
		if (en8 && v7) begin
			y_s8 <= y_s7;
			last_s8 <= last_s7;
			out_s8 <= spec_s7 ? specv_s7 : round_pack(sgn_s7, e_s7, m_s7);
		end
	end

	assign m_tvalid = v8;
	assign m_tdata = alpha_zero ? {y_s8.sig, y_s8.se} : {out_s8.sig, out_s8.se};
	assign m_tlast = last_s8;

	`EAS_CHECK(a_ready_follows_sink, m_tready |-> s_tready)
	`EAS_CHECK(a_bypass_y, m_tvalid && alpha_zero |-> m_tdata[15:0] == y_s8.se && m_tdata[79:16] == y_s8.sig)
	`EAS_CHECK(a_top_exp_has_ib, m_tvalid && !alpha_zero && m_tdata[14:0] == EMAX |-> m_tdata[79])
	`EAS_CHECK_NEXT(a_accept_fills_s1, s_tvalid && s_tready, v1)

endmodule
